>>> src/scfd_pkg.sv
// Shared constants and types of the stereo cross-feedback delay.
`default_nettype none

package scfd_pkg;

  // Delay line geometry; the depth is a power of two.
  localparam int unsigned LINE_DEPTH = 4096;
  localparam int unsigned LINE_AW    = $clog2(LINE_DEPTH);

  // Data widths.
  localparam int unsigned SAMPLE_W = 16;  // Q1.15 samples
  localparam int unsigned LINE_W   = 18;  // Q3.15 stored values
  localparam int unsigned TAP_W    = 12;
  localparam int unsigned GAIN_W   = 16;  // Q0.16 gains
  localparam int unsigned DRY_W    = GAIN_W + 1;
  localparam int unsigned FRAC_W   = 16;  // fraction bits dropped after a gain product
  localparam int unsigned ROUND_HALF = 1 << (FRAC_W - 1);

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAP_LEFT  = 2'd0,
    CFG_TAP_RIGHT = 2'd1,
    CFG_FB_GAIN   = 2'd2,
    CFG_WET_GAIN  = 2'd3
  } cfg_idx_e;

  // Register values after reset.
  localparam int unsigned TAP_LEFT_RESET  = 2016;
  localparam int unsigned TAP_RIGHT_RESET = 3072;
  localparam int unsigned FB_RESET        = 9830;
  localparam int unsigned WET_RESET       = 11796;
  localparam int unsigned DRY_RESET       = (1 << GAIN_W) - WET_RESET;

endpackage

`default_nettype wire

>>> src/scfd_if.sv
// Stream channels of the stereo cross-feedback delay: input pair and output pair.
`default_nettype none

interface scfd_in_if;
  import scfd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] in_left;
  logic signed [SAMPLE_W-1:0] in_right;

  modport source (output valid, output in_left, output in_right, input ready);
  modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

interface scfd_out_if;
  import scfd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_left;
  logic signed [SAMPLE_W-1:0] out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

`default_nettype wire

>>> src/scfd_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
`default_nettype none

module scfd_ram #(
  parameter  int unsigned WIDTH = 18,
  parameter  int unsigned DEPTH = 4096,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output var  logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/stereo_cross_feedback_delay_top.sv
// Stereo cross-feedback delay: two delay lines in RAM, three-stage read-multiply-write pipeline.
//
// Each input beat carries one stereo pair of Q1.15 samples and yields one output beat with the
// dry/wet blend of each side. Both delay lines (Q3.15, 18 bits) sit in one RAM each and share a
// write position; each side reads its line tap samples behind that position, and stores its own
// input plus the other side's delayed sample times the feedback gain, so echoes alternate sides.
// An item is accepted, then the RAMs return the delayed samples and the gain products are formed,
// then rounding and saturation produce the stored values (written back) and the outputs (held in
// an output register). Throughput is one item per cycle while the output is not stalled and both
// taps are zero or at least three. A tap of one or two makes a new item wait until the RAM write
// of the item it reads has landed. Entries that the write position has not yet passed read as
// zero until it first wraps; this is tracked by a fill flag, so no clearing pass runs after
// reset and the block takes items at once. Write the configuration registers only while no item
// is in flight.
`default_nettype none

module stereo_cross_feedback_delay_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  scfd_in_if.sink                               in_i,
  scfd_out_if.source                            out_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [scfd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [scfd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import scfd_pkg::*;

  // Product and rounding widths.
  localparam int unsigned FB_PW  = LINE_W + GAIN_W + 1;      // delayed sample x feedback gain
  localparam int unsigned DX_PW  = SAMPLE_W + DRY_W + 1;     // input x dry gain
  localparam int unsigned SUM_W  = FB_PW + 1;                // rounded sums
  localparam int unsigned Q16_W  = SUM_W - FRAC_W;           // after dropping the fraction
  localparam int unsigned ST_W   = Q16_W + 1;                // input plus feedback term
  localparam int unsigned DIFF_W = (LINE_AW > TAP_W) ? LINE_AW : TAP_W;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] xl;
    logic signed [SAMPLE_W-1:0] xr;
    logic [LINE_AW-1:0]         waddr;
    logic                       lok;   // left read hit a written entry
    logic                       rok;
  } s1_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] xl;
    logic signed [SAMPLE_W-1:0] xr;
    logic [LINE_AW-1:0]         waddr;
    logic signed [FB_PW-1:0]    fbl;   // right delayed sample x feedback, feeds the left line
    logic signed [FB_PW-1:0]    fbr;
    logic signed [DX_PW-1:0]    dxl;   // dry terms
    logic signed [DX_PW-1:0]    dxr;
    logic signed [FB_PW-1:0]    wtl;   // wet terms
    logic signed [FB_PW-1:0]    wtr;
  } s2_t;

  // Clamp helpers.
  function automatic logic signed [LINE_W-1:0] sat_line(input logic signed [ST_W-1:0] v);
    logic fits;
    fits = (v[ST_W-1:LINE_W-1] == '0) || (v[ST_W-1:LINE_W-1] == '1);
    if (fits) begin
      return v[LINE_W-1:0];
    end else if (v[ST_W-1]) begin
      return {1'b1, {(LINE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(LINE_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [Q16_W-1:0] v);
    logic fits;
    fits = (v[Q16_W-1:SAMPLE_W-1] == '0) || (v[Q16_W-1:SAMPLE_W-1] == '1);
    if (fits) begin
      return v[SAMPLE_W-1:0];
    end else if (v[Q16_W-1]) begin
      return {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [TAP_W-1:0]  tap_left_q;
  logic [TAP_W-1:0]  tap_right_q;
  logic [GAIN_W-1:0] fb_q;
  logic [GAIN_W-1:0] wet_q;
  logic [DRY_W-1:0]  dry_q;      // one minus wet, kept ready for the multiplier

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_left_q  <= TAP_W'(TAP_LEFT_RESET);
      tap_right_q <= TAP_W'(TAP_RIGHT_RESET);
      fb_q        <= GAIN_W'(FB_RESET);
      wet_q       <= GAIN_W'(WET_RESET);
      dry_q       <= DRY_W'(DRY_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TAP_LEFT:  tap_left_q  <= cfg_data_i[TAP_W-1:0];
        CFG_TAP_RIGHT: tap_right_q <= cfg_data_i[TAP_W-1:0];
        CFG_FB_GAIN:   fb_q        <= cfg_data_i[GAIN_W-1:0];
        CFG_WET_GAIN: begin
          wet_q <= cfg_data_i[GAIN_W-1:0];
          dry_q <= DRY_W'(1 << GAIN_W) - DRY_W'(cfg_data_i[GAIN_W-1:0]);
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  logic               s1_valid_q, s2_valid_q, out_valid_q;
  s1_t                s1_q;
  s2_t                s2_q;
  logic [LINE_AW-1:0] wp_q;
  logic               full_q;     // write position has wrapped: every entry written
  logic               s1_adv, s2_adv, in_acc, hazard;
  logic [DIFF_W-1:0]  diff_l, diff_r;
  logic [LINE_AW-1:0] raddr_l, raddr_r;

  // Read addresses, tap taken modulo the line depth.
  assign diff_l  = DIFF_W'(wp_q) - DIFF_W'(tap_left_q);
  assign diff_r  = DIFF_W'(wp_q) - DIFF_W'(tap_right_q);
  assign raddr_l = diff_l[LINE_AW-1:0];
  assign raddr_r = diff_r[LINE_AW-1:0];

  // Hold a new item while an item in flight has yet to write the entry it reads.
  assign hazard = (s1_valid_q && (raddr_l == s1_q.waddr || raddr_r == s1_q.waddr)) ||
                  (s2_valid_q && (raddr_l == s2_q.waddr || raddr_r == s2_q.waddr));

  assign s2_adv    = s2_valid_q && (!out_valid_q || out_o.ready);
  assign s1_adv    = s1_valid_q && (!s2_valid_q || s2_adv);
  assign in_i.ready = (!s1_valid_q || s1_adv) && !hazard;
  assign in_acc    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      wp_q        <= '0;
      full_q      <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_q <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      // Advance the shared write position per accepted beat.
      if (in_acc) begin
        wp_q <= wp_q + 1'b1;
        if (wp_q == LINE_AW'(LINE_DEPTH - 1)) begin
          full_q <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Delay line RAMs
  // --------------------------------------------------------------------------
  logic [LINE_W-1:0]        rdata_l, rdata_r;
  logic signed [LINE_W-1:0] store_l, store_r;

  scfd_ram #(.WIDTH(LINE_W), .DEPTH(LINE_DEPTH)) u_left_line (
    .clk_i   (clk_i),
    .we_i    (s2_adv),
    .waddr_i (s2_q.waddr),
    .wdata_i (store_l),
    .re_i    (in_acc),
    .raddr_i (raddr_l),
    .rdata_o (rdata_l)
  );

  scfd_ram #(.WIDTH(LINE_W), .DEPTH(LINE_DEPTH)) u_right_line (
    .clk_i   (clk_i),
    .we_i    (s2_adv),
    .waddr_i (s2_q.waddr),
    .wdata_i (store_r),
    .re_i    (in_acc),
    .raddr_i (raddr_r),
    .rdata_o (rdata_r)
  );

  // --------------------------------------------------------------------------
  // Stage 1: delayed samples and gain products
  // --------------------------------------------------------------------------
  logic signed [LINE_W-1:0] dl, dr;
  s2_t                      s2_d;

  // Entries never written read as zero.
  assign dl = s1_q.lok ? $signed(rdata_l) : '0;
  assign dr = s1_q.rok ? $signed(rdata_r) : '0;

  always_comb begin
    s2_d       = '0;
    s2_d.xl    = s1_q.xl;
    s2_d.xr    = s1_q.xr;
    s2_d.waddr = s1_q.waddr;
    s2_d.fbl   = dr * $signed({1'b0, fb_q});
    s2_d.fbr   = dl * $signed({1'b0, fb_q});
    s2_d.dxl   = s1_q.xl * $signed({1'b0, dry_q});
    s2_d.dxr   = s1_q.xr * $signed({1'b0, dry_q});
    s2_d.wtl   = dl * $signed({1'b0, wet_q});
    s2_d.wtr   = dr * $signed({1'b0, wet_q});
  end

  // --------------------------------------------------------------------------
  // Stage 2: round, saturate, write back and blend
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0] fbl_rnd, fbr_rnd, mixl_rnd, mixr_rnd;
  logic signed [ST_W-1:0]  sum_l, sum_r;

  always_comb begin
    fbl_rnd  = SUM_W'(s2_q.fbl) + SUM_W'(ROUND_HALF);
    fbr_rnd  = SUM_W'(s2_q.fbr) + SUM_W'(ROUND_HALF);
    sum_l    = ST_W'(s2_q.xl) + ST_W'($signed(fbl_rnd[SUM_W-1:FRAC_W]));
    sum_r    = ST_W'(s2_q.xr) + ST_W'($signed(fbr_rnd[SUM_W-1:FRAC_W]));
    store_l  = sat_line(sum_l);
    store_r  = sat_line(sum_r);
    mixl_rnd = SUM_W'(s2_q.dxl) + SUM_W'(s2_q.wtl) + SUM_W'(ROUND_HALF);
    mixr_rnd = SUM_W'(s2_q.dxr) + SUM_W'(s2_q.wtr) + SUM_W'(ROUND_HALF);
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] out_left_q, out_right_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.xl    <= in_i.in_left;
      s1_q.xr    <= in_i.in_right;
      s1_q.waddr <= wp_q;
      s1_q.lok   <= full_q || (raddr_l < wp_q);
      s1_q.rok   <= full_q || (raddr_r < wp_q);
    end
    if (s1_adv) begin
      s2_q <= s2_d;
    end
    if (s2_adv) begin
      out_left_q  <= sat_out($signed(mixl_rnd[SUM_W-1:FRAC_W]));
      out_right_q <= sat_out($signed(mixr_rnd[SUM_W-1:FRAC_W]));
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_left  = out_left_q;
  assign out_o.out_right = out_right_q;

endmodule

`default_nettype wire

>>> src/scfd_checker.sv
// Port-level checks of the stereo cross-feedback delay, bound to its top level.
`default_nettype none

module scfd_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_ready_i,
  input wire logic                             out_valid_i,
  input wire logic                             out_ready_i,
  input wire logic [scfd_pkg::SAMPLE_W-1:0]    out_left_i,
  input wire logic [scfd_pkg::SAMPLE_W-1:0]    out_right_i
);

  // Items accepted but not yet delivered.
  logic [2:0] occ_q, occ_d;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  always_comb begin
    occ_d = occ_q;
    if (in_beat && !out_beat) begin
      occ_d = occ_q + 3'd1;
    end else if (out_beat && !in_beat) begin
      occ_d = occ_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // Three places hold items: two pipeline stages and the output register.
  a_occ_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= 3'd3)
    else $error("more items in flight than the pipeline holds");

  a_out_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> occ_q != 3'd0)
    else $error("output beat with no accepted item behind it");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_left_i) && $stable(out_right_i))
    else $error("output payload changed while stalled");

endmodule

bind stereo_cross_feedback_delay_top scfd_checker u_scfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_left_i  (out_o.out_left),
  .out_right_i (out_o.out_right)
);

`default_nettype wire
